>>> rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, masked during reset.
`define VGRE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");

// Implication checked in the next cycle, masked during reset.
`define VGRE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Property that also holds while reset is asserted.
`define VGRE_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) (ante) |-> (cons)) \
    else $error("reset check failed");

`endif

>>> rtl/vgre_pkg.sv
// ----------------------------------------------------------------------------
// vgre_pkg
// Shared types, constants and arithmetic helpers of the volume gradient
// encoder: register indexes, smoothing weights and the code mapping.
// ----------------------------------------------------------------------------
package vgre_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_DEPTH  = 4096;

  localparam int SAMPLE_W = 8;
  localparam int CODE_W   = 8;
  localparam int CFG_W    = 13;
  localparam int SUM_W    = 15;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_DIM_X = 2'd0,
    CFG_DIM_Y = 2'd1,
    CFG_DIM_Z = 2'd2
  } cfg_idx_e;

  // Smoothing weight [1,4,1] x [1,4,1] as shift amounts, row-major
  localparam int unsigned WSH [9] = '{0, 2, 0, 2, 4, 2, 0, 2, 0};

  // Reciprocal of 9 in 0.16 fixed point, exact for dividends below 2304
  localparam logic [12:0] RECIP9 = 13'd7282;
  localparam logic [11:0] QSAT   = 12'd2304;

  // Per-item control riding the pipeline
  typedef struct packed {
    logic       emit;
    logic       last;
    logic [2:0] mx;
    logic [2:0] my;
    logic [2:0] mz;
  } ctl_t;

  // Weighted difference sum over the nine smoothed lanes
  function automatic logic signed [SUM_W-1:0] axis_sum(
    input logic [8:0][SAMPLE_W-1:0] hi,
    input logic [8:0][SAMPLE_W-1:0] lo
  );
    logic signed [SUM_W-1:0] acc;
    logic signed [8:0]       d;
    logic signed [SUM_W-1:0] de;
    acc = '0;
    for (int k = 0; k < 9; k++) begin
      d   = $signed({1'b0, hi[k]}) - $signed({1'b0, lo[k]});
      de  = $signed({{(SUM_W-9){d[8]}}, d});
      acc = acc + (de <<< WSH[k]);
    end
    return acc;
  endfunction

  // floor((255*s + 18432) / 144) saturated to 0..255
  function automatic logic [CODE_W-1:0] encode(input logic signed [SUM_W-1:0] s);
    logic signed [24:0] se;
    logic signed [24:0] num;
    logic [20:0]        nq;
    logic [24:0]        prod;
    logic [CODE_W-1:0]  q;
    se   = $signed({{(25-SUM_W){s[SUM_W-1]}}, s});
    num  = (se <<< 8) - se + 25'sd18432;
    nq   = num[24:4];
    prod = 25'(nq[11:0]) * 25'(RECIP9);
    if (num[24]) begin
      q = '0;
    end else if (nq >= 21'(QSAT)) begin
      q = 8'd255;
    end else begin
      q = prod[23:16];
    end
    return q;
  endfunction

endpackage

>>> rtl/vgre_ifs.sv
// ----------------------------------------------------------------------------
// vgre_ifs
// Valid/ready stream channels: voxel input and RGBA result output.
// ----------------------------------------------------------------------------
interface vgre_in_if;
  import vgre_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                drain;
  modport source(output valid, output sample, output drain, input ready);
  modport sink(input valid, input sample, input drain, output ready);
endinterface

interface vgre_out_if;
  import vgre_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] grad_x_code;
  logic [CODE_W-1:0] grad_y_code;
  logic [CODE_W-1:0] grad_z_code;
  logic [CODE_W-1:0] alpha_value;
  logic              last_voxel;
  modport source(output valid, output grad_x_code, output grad_y_code,
                 output grad_z_code, output alpha_value, output last_voxel,
                 input ready);
  modport sink(input valid, input grad_x_code, input grad_y_code,
               input grad_z_code, input alpha_value, input last_voxel,
               output ready);
endinterface

>>> rtl/volume_gradient_rgba_encoder.sv
// ----------------------------------------------------------------------------
// volume_gradient_rgba_encoder
// Smoothed central-difference 3D gradient to RGBA code, streaming.
// ----------------------------------------------------------------------------
// Takes one item per clock and holds that rate as long as results are taken;
// the five register stages (slice ring read, row ring read, 3x3x3 window,
// gradient sums, code register) lie between the edge that accepts an item
// and its result on the output, and input ready drops only when the result
// register is stalled and every stage is full. Results trail the voxel stream
// by X*Y + X + 1 items, which drain items supply after the last voxel. The
// slice ring (2*MAX_WIDTH*MAX_HEIGHT bytes) and the row ring (2*MAX_WIDTH
// words of three planes) need no clear after reset, since out-of-volume
// neighbors are masked to zero. A write to a dimension register restarts the volume at
// voxel (0,0,0).
module volume_gradient_rgba_encoder #(
  parameter int MAX_WIDTH  = vgre_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = vgre_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_DEPTH  = vgre_pkg::DEF_MAX_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  vgre_pkg::cfg_idx_e       cfg_idx_i,
  input  logic [vgre_pkg::CFG_W-1:0] cfg_data_i,
  vgre_in_if.sink                  vox_i,
  vgre_out_if.source               res_o
);
  import vgre_pkg::*;

  localparam int WX     = $clog2(MAX_WIDTH + 1);
  localparam int WY     = $clog2(MAX_HEIGHT + 1);
  localparam int WZ     = $clog2(MAX_DEPTH + 1);
  localparam int WXY    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int WD     = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 2);
  localparam int PDEPTH = 2 * MAX_WIDTH * MAX_HEIGHT;
  localparam int RDEPTH = 2 * MAX_WIDTH;
  localparam int RST_X  = (256 > MAX_WIDTH)  ? MAX_WIDTH  : 256;
  localparam int RST_Y  = (256 > MAX_HEIGHT) ? MAX_HEIGHT : 256;
  localparam int RST_Z  = (256 > MAX_DEPTH)  ? MAX_DEPTH  : 256;

  // clamped dimensions and derived sizes
  logic [WX-1:0]  nx_q, nx_d;
  logic [WY-1:0]  ny_q, ny_d;
  logic [WZ-1:0]  nz_q, nz_d;
  logic [WXY-1:0] xy_q, xy_d;
  logic [WD-1:0]  d_q, d_d;
  logic           cfg_hit;
  logic [31:0]    raw_x, raw_y, raw_z;

  // stream position
  logic [WX-1:0]  in_x_q, px_q;
  logic [WY-1:0]  in_y_q, py_q;
  logic [WZ-1:0]  in_z_q, pz_q;
  logic           in_done_q;
  logic [WD-1:0]  lag_q;

  logic           acc, adv, voxel, emit, last_c, in_last;
  ctl_t           ctl_new;

  // stage handshake
  logic           go_o, en4, en3, en2, en1;
  logic           v1_q, v2_q, v3_q, v4_q, ov_q;

  // stage payload
  logic [SAMPLE_W-1:0]         s1_sample_q;
  ctl_t                        s1_ctl_q, s2_ctl_q, s3_ctl_q;
  logic [SAMPLE_W-1:0]         pl1, pl2;
  logic [2:0][SAMPLE_W-1:0]    s2_u_q;
  logic [3*SAMPLE_W-1:0]       row1, row2;
  logic [SAMPLE_W-1:0]         tap_q [3][3][3];
  logic [SAMPLE_W-1:0]         win   [3][3][3];
  logic [8:0][SAMPLE_W-1:0]    hx, lx, hy, ly, hz, lz;
  logic signed [SUM_W-1:0]     sx_q, sy_q, sz_q;
  logic [SAMPLE_W-1:0]         s4_alpha_q;
  logic                        s4_last_q;
  logic [CODE_W-1:0]           gx_q, gy_q, gz_q, al_q;
  logic                        lv_q;

  // configuration: clamp on write, derive X*Y and the result delay
  always_comb begin
    raw_x = 32'(cfg_data_i[8:0]);
    raw_y = 32'(cfg_data_i[8:0]);
    raw_z = 32'(cfg_data_i[12:0]);
    nx_d  = nx_q;
    ny_d  = ny_q;
    nz_d  = nz_q;
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DIM_X: begin
          cfg_hit = 1'b1;
          nx_d = (raw_x == 0) ? WX'(1) :
                 ((raw_x > 32'(MAX_WIDTH)) ? WX'(MAX_WIDTH) : WX'(raw_x));
        end
        CFG_DIM_Y: begin
          cfg_hit = 1'b1;
          ny_d = (raw_y == 0) ? WY'(1) :
                 ((raw_y > 32'(MAX_HEIGHT)) ? WY'(MAX_HEIGHT) : WY'(raw_y));
        end
        CFG_DIM_Z: begin
          cfg_hit = 1'b1;
          nz_d = (raw_z == 0) ? WZ'(1) :
                 ((raw_z > 32'(MAX_DEPTH)) ? WZ'(MAX_DEPTH) : WZ'(raw_z));
        end
        default: cfg_hit = 1'b0;
      endcase
    end
    xy_d = WXY'(WXY'(nx_d) * WXY'(ny_d));
    d_d  = WD'(WD'(nx_d) * (WD'(ny_d) + WD'(1)) + WD'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nx_q <= WX'(RST_X);
      ny_q <= WY'(RST_Y);
      nz_q <= WZ'(RST_Z);
      xy_q <= WXY'(RST_X * RST_Y);
      d_q  <= WD'(RST_X * RST_Y + RST_X + 1);
    end else if (cfg_hit) begin
      nx_q <= nx_d;
      ny_q <= ny_d;
      nz_q <= nz_d;
      xy_q <= xy_d;
      d_q  <= d_d;
    end
  end

  // handshake chain: each stage moves when the next one is empty or moving
  assign go_o = !ov_q || res_o.ready;
  assign en4  = !v4_q || go_o;
  assign en3  = !v3_q || en4;
  assign en2  = !v2_q || en3;
  assign en1  = !v1_q || en2;
  assign vox_i.ready = en1;

  // item classification and neighbor masks of the centre voxel
  always_comb begin
    acc     = vox_i.valid && vox_i.ready;
    adv     = acc && (in_done_q || !vox_i.drain);
    voxel   = acc && !in_done_q && !vox_i.drain;
    emit    = (lag_q == d_q);
    last_c  = (px_q == nx_q - WX'(1)) && (py_q == ny_q - WY'(1)) &&
              (pz_q == nz_q - WZ'(1));
    in_last = (in_x_q == nx_q - WX'(1)) && (in_y_q == ny_q - WY'(1)) &&
              (in_z_q == nz_q - WZ'(1));
    ctl_new.emit = emit;
    ctl_new.last = last_c;
    ctl_new.mx   = {px_q != nx_q - WX'(1), 1'b1, px_q != '0};
    ctl_new.my   = {py_q != ny_q - WY'(1), 1'b1, py_q != '0};
    ctl_new.mz   = {pz_q != nz_q - WZ'(1), 1'b1, pz_q != '0};
  end

  // stream counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_x_q <= '0; in_y_q <= '0; in_z_q <= '0; in_done_q <= 1'b0;
      lag_q  <= '0; px_q   <= '0; py_q   <= '0; pz_q      <= '0;
    end else if (cfg_hit) begin
      in_x_q <= '0; in_y_q <= '0; in_z_q <= '0; in_done_q <= 1'b0;
      lag_q  <= '0; px_q   <= '0; py_q   <= '0; pz_q      <= '0;
    end else if (adv) begin
      if (voxel) begin
        if (in_last) begin
          in_done_q <= 1'b1;
        end
        if (in_x_q == nx_q - WX'(1)) begin
          in_x_q <= '0;
          if (in_y_q == ny_q - WY'(1)) begin
            in_y_q <= '0;
            in_z_q <= in_z_q + WZ'(1);
          end else begin
            in_y_q <= in_y_q + WY'(1);
          end
        end else begin
          in_x_q <= in_x_q + WX'(1);
        end
      end
      if (!emit) begin
        lag_q <= lag_q + WD'(1);
      end else if (last_c) begin
        in_x_q <= '0; in_y_q <= '0; in_z_q <= '0; in_done_q <= 1'b0;
        lag_q  <= '0; px_q   <= '0; py_q   <= '0; pz_q      <= '0;
      end else if (px_q == nx_q - WX'(1)) begin
        px_q <= '0;
        if (py_q == ny_q - WY'(1)) begin
          py_q <= '0;
          pz_q <= pz_q + WZ'(1);
        end else begin
          py_q <= py_q + WY'(1);
        end
      end else begin
        px_q <= px_q + WX'(1);
      end
    end
  end

  // slice ring: planes one and two slices back
  vgre_ring_ram #(
    .DEPTH (PDEPTH),
    .WIDTH (SAMPLE_W),
    .OFF_W (WXY)
  ) u_slice_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .wdata_i   (vox_i.sample),
    .off_i     (xy_q),
    .rdata_a_o (pl1),
    .rdata_b_o (pl2)
  );

  // row ring: three planes side by side, rows one and two back
  vgre_ring_ram #(
    .DEPTH (RDEPTH),
    .WIDTH (3 * SAMPLE_W),
    .OFF_W (WX)
  ) u_row_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en2 && v1_q),
    .wdata_i   ({pl2, pl1, s1_sample_q}),
    .off_i     (nx_q),
    .rdata_a_o (row1),
    .rdata_b_o (row2)
  );

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (en1) v1_q <= adv;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q && s3_ctl_q.emit;
      if (go_o) ov_q <= v4_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (en1 && adv) begin
      s1_sample_q <= vox_i.sample;
      s1_ctl_q    <= ctl_new;
    end
    if (en2 && v1_q) begin
      s2_u_q   <= {pl2, pl1, s1_sample_q};
      s2_ctl_q <= s1_ctl_q;
    end
    if (en3 && v2_q) begin
      s3_ctl_q <= s2_ctl_q;
      for (int a = 0; a < 3; a++) begin
        tap_q[a][0][0] <= s2_u_q[a];
        tap_q[a][1][0] <= row1[a*SAMPLE_W +: SAMPLE_W];
        tap_q[a][2][0] <= row2[a*SAMPLE_W +: SAMPLE_W];
        for (int b = 0; b < 3; b++) begin
          tap_q[a][b][1] <= tap_q[a][b][0];
          tap_q[a][b][2] <= tap_q[a][b][1];
        end
      end
    end
    if (en4 && v3_q) begin
      sx_q       <= axis_sum(hx, lx);
      sy_q       <= axis_sum(hy, ly);
      sz_q       <= axis_sum(hz, lz);
      s4_alpha_q <= tap_q[1][1][1];
      s4_last_q  <= s3_ctl_q.last;
    end
    if (go_o && v4_q) begin
      gx_q <= encode(sx_q);
      gy_q <= encode(sy_q);
      gz_q <= encode(sz_q);
      al_q <= s4_alpha_q;
      lv_q <= s4_last_q;
    end
  end

  // masked window, indexed [z][y][x] with 0 meaning -1
  always_comb begin
    for (int iz = 0; iz < 3; iz++) begin
      for (int iy = 0; iy < 3; iy++) begin
        for (int ix = 0; ix < 3; ix++) begin
          win[iz][iy][ix] = (s3_ctl_q.mz[iz] && s3_ctl_q.my[iy] && s3_ctl_q.mx[ix]) ?
                            tap_q[2-iz][2-iy][2-ix] : '0;
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        hx[i*3+j] = win[i][j][2];
        lx[i*3+j] = win[i][j][0];
        hy[i*3+j] = win[i][2][j];
        ly[i*3+j] = win[i][0][j];
        hz[i*3+j] = win[2][i][j];
        lz[i*3+j] = win[0][i][j];
      end
    end
  end

  assign res_o.valid       = ov_q;
  assign res_o.grad_x_code = gx_q;
  assign res_o.grad_y_code = gy_q;
  assign res_o.grad_z_code = gz_q;
  assign res_o.alpha_value = al_q;
  assign res_o.last_voxel  = lv_q;

endmodule

>>> rtl/vgre_ring_ram.sv
// ----------------------------------------------------------------------------
// vgre_ring_ram
// Circular history memory: one write per enabled cycle at a running pointer,
// two registered reads at the pointer minus off and minus twice off.
// ----------------------------------------------------------------------------
module vgre_ring_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 8,
  parameter int OFF_W = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [OFF_W-1:0] off_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = AW + 2;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wp_q, wp_d;
  logic [AW-1:0]    ra, rb;
  logic [SW-1:0]    da, db;
  logic [WIDTH-1:0] rda_q, rdb_q;

  // read addresses, wrapped back into the ring
  always_comb begin
    da = SW'(wp_q) - SW'(off_i);
    db = SW'(wp_q) - (SW'(off_i) << 1);
    ra = da[SW-1] ? AW'(da + SW'(DEPTH)) : AW'(da);
    rb = db[SW-1] ? AW'(db + SW'(DEPTH)) : AW'(db);
    wp_d = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
    end else if (en_i) begin
      wp_q <= wp_d;
    end
  end

  // read-before-write: a read at the write address returns the old entry
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mem[wp_q] <= wdata_i;
      rda_q     <= mem[ra];
      rdb_q     <= mem[rb];
    end
  end

  assign rdata_a_o = rda_q;
  assign rdata_b_o = rdb_q;

endmodule

>>> rtl/vgre_checker.sv
// ----------------------------------------------------------------------------
// vgre_checker
// Port-level checks of the encoder: stall behavior and result channel hold.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vgre_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_gx_i,
  input logic       out_last_i
);

  // input side stalls only behind a blocked result
  `VGRE_ASSERT_IMP(a_stall_cause, !in_ready_i, out_valid_i && !out_ready_i)

  // reset empties the result register
  `VGRE_ASSERT_RST(a_rst_empty, !rst_ni, !out_valid_i)

  // a blocked result stays offered
  `VGRE_ASSERT_NXT(a_valid_hold, out_valid_i && !out_ready_i, out_valid_i)

  // a blocked result keeps its x code and last flag
  `VGRE_ASSERT_NXT(a_data_hold, out_valid_i && !out_ready_i,
                   $stable(out_gx_i) && $stable(out_last_i))

endmodule

bind volume_gradient_rgba_encoder vgre_checker u_vgre_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (vox_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_gx_i    (res_o.grad_x_code),
  .out_last_i  (res_o.last_voxel)
);
